### rtl/streaming_integer_text_parser_unit_macros.svh
// Assertion macros shared by the integer text parser modules.
`ifndef STREAMING_INTEGER_TEXT_PARSER_UNIT_MACROS_SVH
`define STREAMING_INTEGER_TEXT_PARSER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, reset masked.
`define SITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sitp: same-cycle check failed");
// Next-cycle implication, reset masked.
`define SITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sitp: next-cycle check failed");
`else
`define SITP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SITP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/sitp_pkg.sv
// Package: codes, types and helpers of the integer text parser.
`timescale 1ns / 1ps
package sitp_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned BASE_W     = 5;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned BITS_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned WORTH_W    = 4;
  localparam int unsigned PROD_W     = VALUE_W + 4;

  // transaction commands
  localparam logic [CMD_W-1:0] CMD_PUSH        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FINISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH      = 2'd2;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  // base modes
  localparam logic [MODE_W-1:0] BM_DEC  = 3'd0;
  localparam logic [MODE_W-1:0] BM_HEX  = 3'd1;
  localparam logic [MODE_W-1:0] BM_OCT  = 3'd2;
  localparam logic [MODE_W-1:0] BM_BIN  = 3'd3;
  localparam logic [MODE_W-1:0] BM_AUTO = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESULT_SIGNED = 2'd2;

  localparam logic [BASE_W-1:0] BASE_2  = 5'd2;
  localparam logic [BASE_W-1:0] BASE_8  = 5'd8;
  localparam logic [BASE_W-1:0] BASE_10 = 5'd10;
  localparam logic [BASE_W-1:0] BASE_16 = 5'd16;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  localparam logic [BITS_W-1:0] BITS_MIN   = 7'd8;
  localparam logic [BITS_W-1:0] BITS_MAX   = 7'd64;
  localparam logic [BITS_W-1:0] BITS_RESET = 7'd32;

  typedef struct packed {
    logic load;     // input transaction accepted, capture the character
    logic do_char;  // apply character rules
    logic do_acc;   // add digit to product, check overflow
    logic do_fin;   // load result register and clear field state
  } sitp_cmd_t;

  typedef struct packed {
    logic take_digit;  // current character is a digit that must be accumulated
  } sitp_sts_t;

  function automatic logic [BASE_W-1:0] base_of_mode(input logic [MODE_W-1:0] mode);
    logic [BASE_W-1:0] b;
    unique case (mode)
      BM_HEX:  b = BASE_16;
      BM_OCT:  b = BASE_8;
      BM_BIN:  b = BASE_2;
      default: b = BASE_10;
    endcase
    return b;
  endfunction

endpackage

### rtl/sitp_if.sv
// Stream interfaces of the integer text parser: character input and result output.
`timescale 1ns / 1ps
interface sitp_in_if;
  import sitp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [CHAR_W-1:0]   char_in;

  modport source (output valid, output cmd, output char_in, input ready);
  modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

interface sitp_out_if;
  import sitp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_W-1:0]    value_out;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output value_out, output status, input ready);
  modport sink   (input valid, input value_out, input status, output ready);
endinterface

### rtl/sitp_ctrl.sv
// Controller: sequences accept, character, accumulate and finish steps.
`timescale 1ns / 1ps
`include "streaming_integer_text_parser_unit_macros.svh"
module sitp_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [sitp_pkg::CMD_W-1:0] in_cmd,
  output logic                    in_ready,
  input  logic                    out_ready,
  output logic                    out_valid,
  input  sitp_pkg::sitp_sts_t     sts_i,
  output sitp_pkg::sitp_cmd_t     cmd_o
);
  import sitp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHAR = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       fin_r, fin_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_fire;
  logic       fin_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  // result register is free when empty or being drained this cycle
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          fin_nxt = (in_cmd == CMD_PUSH_FINISH);
          unique case (in_cmd) inside
            CMD_PUSH, CMD_PUSH_FINISH: state_nxt = S_CHAR;
            CMD_FINISH:                state_nxt = S_FIN;
            default:                   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CHAR: begin
        if (sts_i.take_digit) begin
          state_nxt = S_ACC;
        end else begin
          state_nxt = fin_r ? S_FIN : S_IDLE;
        end
      end
      S_ACC: begin
        state_nxt = fin_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (fin_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = fin_fire || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_comb begin
    cmd_o.load    = in_fire;
    cmd_o.do_char = (state_r == S_CHAR);
    cmd_o.do_acc  = (state_r == S_ACC);
    cmd_o.do_fin  = fin_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SITP_ASSERT_NOW(a_acc_after_digit, clk, rst_n, state_r == S_ACC, $past(state_r == S_CHAR && sts_i.take_digit))
  `SITP_ASSERT_NEXT(a_finish_only, clk, rst_n, in_fire && in_cmd == CMD_FINISH, state_r == S_FIN)
  `SITP_ASSERT_NEXT(a_fin_shows, clk, rst_n, fin_fire, out_valid_r && state_r == S_IDLE)

endmodule

### rtl/sitp_dp.sv
// Datapath: configuration, field state, digit accumulate and result register.
`timescale 1ns / 1ps
`include "streaming_integer_text_parser_unit_macros.svh"
module sitp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sitp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sitp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [sitp_pkg::CHAR_W-1:0]   in_char,
  input  sitp_pkg::sitp_cmd_t           cmd_i,
  output sitp_pkg::sitp_sts_t           sts_o,
  output logic [sitp_pkg::VALUE_W-1:0]  value_out,
  output logic [sitp_pkg::STATUS_W-1:0] status
);
  import sitp_pkg::*;

  logic [MODE_W-1:0]   base_mode_r;
  logic [BITS_W-1:0]   result_bits_r;
  logic                result_signed_r;
  logic [CHAR_W-1:0]   char_r;

  logic [VALUE_W-1:0]  mag_r, mag_nxt;
  logic                ds_r, ds_nxt;
  logic [BASE_W-1:0]   cur_base_r, cur_base_nxt;
  logic                neg_r, neg_nxt;
  logic                ovf_r, ovf_nxt;
  logic                ref_r, ref_nxt;
  logic                lz_r, lz_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [WORTH_W-1:0]  worth_r, worth_nxt;
  logic [VALUE_W-1:0]  value_out_r;
  logic [STATUS_W-1:0] status_r;

  // character decode
  logic                autom, prefix_ok;
  logic                is_sign, is_x, is_zero;
  logic                hex_ok;
  logic [WORTH_W-1:0]  worth;
  logic [BASE_W-1:0]   eff_base;
  logic                digit_ok;
  logic [PROD_W-1:0]   mag_ext;
  logic [PROD_W:0]     acc_sum;

  // finish
  logic [BITS_W-1:0]   bits_c;
  logic [BITS_W-1:0]   nb;
  logic [VALUE_W:0]    lim;
  logic [VALUE_W:0]    mag_wide;
  logic [STATUS_W-1:0] fin_status;
  logic [VALUE_W-1:0]  fin_value;

  always_comb begin
    autom     = (base_mode_r == BM_AUTO);
    prefix_ok = autom || (cur_base_r == BASE_16);
    is_sign   = !ds_r && !lz_r && ((char_r == CH_PLUS) || (char_r == CH_MINUS));
    is_x      = (char_r == CH_LX) || (char_r == CH_UX);
    is_zero   = (char_r == CH_ZERO);

    hex_ok = 1'b1;
    worth  = '0;
    if (char_r >= CH_ZERO && char_r <= CH_NINE) begin
      worth = WORTH_W'(char_r - CH_ZERO);
    end else if (char_r >= CH_LA && char_r <= CH_LF) begin
      worth = WORTH_W'(char_r - CH_LA + 8'd10);
    end else if (char_r >= CH_UA && char_r <= CH_UF) begin
      worth = WORTH_W'(char_r - CH_UA + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end

    // automatic mode: a leading zero followed by anything else means octal
    eff_base = (lz_r && autom && !ds_r) ? BASE_8 : cur_base_r;
    digit_ok = hex_ok && ({1'b0, worth} < eff_base);

    mag_ext = {4'b0, mag_r};
    case (eff_base)
      BASE_16: prod_nxt = mag_ext << 4;
      BASE_8:  prod_nxt = mag_ext << 3;
      BASE_2:  prod_nxt = mag_ext << 1;
      default: prod_nxt = (mag_ext << 3) + (mag_ext << 1);
    endcase
    worth_nxt = worth;

    acc_sum = {1'b0, prod_r} + {{(PROD_W + 1 - WORTH_W){1'b0}}, worth_r};
  end

  assign sts_o.take_digit = cmd_i.do_char && !is_sign
                            && !(lz_r && is_x && prefix_ok)
                            && !(!ds_r && !lz_r && is_zero && prefix_ok)
                            && digit_ok;

  // range check for the destination type
  always_comb begin
    if (result_bits_r < BITS_MIN) begin
      bits_c = BITS_MIN;
    end else if (result_bits_r > BITS_MAX) begin
      bits_c = BITS_MAX;
    end else begin
      bits_c = result_bits_r;
    end
    nb       = bits_c - BITS_W'(result_signed_r);
    lim      = {{VALUE_W{1'b0}}, 1'b1} << nb;
    mag_wide = {1'b0, mag_r};

    fin_value = '0;
    if (ref_r) begin
      fin_status = ST_INVALID;
    end else if (!ds_r && !lz_r) begin
      fin_status = ST_EMPTY;
    end else if (ovf_r) begin
      fin_status = ST_RANGE;
    end else if (neg_r) begin
      if (!result_signed_r) begin
        fin_status = (mag_r != '0) ? ST_RANGE : ST_OK;
      end else if (mag_wide > lim) begin
        fin_status = ST_RANGE;
      end else begin
        fin_status = ST_OK;
        fin_value  = ~mag_r + VALUE_W'(1);
      end
    end else if (mag_wide >= lim) begin
      fin_status = ST_RANGE;
    end else begin
      fin_status = ST_OK;
      fin_value  = mag_r;
    end
  end

  // field state update
  always_comb begin
    mag_nxt      = mag_r;
    ds_nxt       = ds_r;
    cur_base_nxt = cur_base_r;
    neg_nxt      = neg_r;
    ovf_nxt      = ovf_r;
    ref_nxt      = ref_r;
    lz_nxt       = lz_r;
    if (cmd_i.do_char) begin
      if (is_sign) begin
        if (neg_r || (mag_r != '0)) begin
          ref_nxt = 1'b1;
        end else begin
          neg_nxt = (char_r == CH_MINUS);
        end
      end else if (lz_r && is_x && prefix_ok) begin
        cur_base_nxt = BASE_16;
        lz_nxt       = 1'b0;
        ds_nxt       = 1'b0;
      end else if (!ds_r && !lz_r && is_zero && prefix_ok) begin
        lz_nxt = 1'b1;
      end else begin
        cur_base_nxt = eff_base;
        if (!digit_ok) begin
          ref_nxt = 1'b1;
        end else begin
          ds_nxt = 1'b1;
        end
      end
    end else if (cmd_i.do_acc) begin
      if (acc_sum[PROD_W:VALUE_W] != '0) begin
        ovf_nxt = 1'b1;
      end else begin
        mag_nxt = acc_sum[VALUE_W-1:0];
      end
    end else if (cmd_i.do_fin) begin
      mag_nxt      = '0;
      ds_nxt       = 1'b0;
      cur_base_nxt = base_of_mode(base_mode_r);
      neg_nxt      = 1'b0;
      ovf_nxt      = 1'b0;
      ref_nxt      = 1'b0;
      lz_nxt       = 1'b0;
    end else if (cfg_we && cfg_index == REG_BASE_MODE) begin
      cur_base_nxt = base_of_mode(cfg_wdata[MODE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_mode_r     <= BM_DEC;
      result_bits_r   <= BITS_RESET;
      result_signed_r <= 1'b1;
      mag_r           <= '0;
      ds_r            <= 1'b0;
      cur_base_r      <= BASE_10;
      neg_r           <= 1'b0;
      ovf_r           <= 1'b0;
      ref_r           <= 1'b0;
      lz_r            <= 1'b0;
      value_out_r     <= '0;
      status_r        <= ST_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE_MODE:     base_mode_r     <= cfg_wdata[MODE_W-1:0];
          REG_RESULT_BITS:   result_bits_r   <= cfg_wdata[BITS_W-1:0];
          REG_RESULT_SIGNED: result_signed_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      mag_r      <= mag_nxt;
      ds_r       <= ds_nxt;
      cur_base_r <= cur_base_nxt;
      neg_r      <= neg_nxt;
      ovf_r      <= ovf_nxt;
      ref_r      <= ref_nxt;
      lz_r       <= lz_nxt;
      if (cmd_i.do_fin) begin
        value_out_r <= fin_value;
        status_r    <= fin_status;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      char_r <= in_char;
    end
    if (sts_o.take_digit) begin
      prod_r  <= prod_nxt;
      worth_r <= worth_nxt;
    end
  end

  assign value_out = value_out_r;
  assign status    = status_r;

  `SITP_ASSERT_NOW(a_err_zero, clk, rst_n, value_out_r != '0, status_r == ST_OK)
  `SITP_ASSERT_NEXT(a_fin_clears, clk, rst_n, cmd_i.do_fin, mag_r == '0 && !ref_r && !ovf_r && !ds_r && !lz_r)
  `SITP_ASSERT_NOW(a_one_step, clk, rst_n, cmd_i.do_acc, !cmd_i.do_char && !cmd_i.do_fin)

endmodule

### rtl/streaming_integer_text_parser_unit.sv
// Streaming integer text parser: a character per transaction, a value per field.
// Steps: a finish-only transaction goes straight to S_FIN; a pushed character passes S_CHAR,
// and a digit also S_ACC (a multiply step, then an add step), and S_FIN if it ends the field.
// out_valid is registered and rises after S_FIN loads the result register; a finish waits
// while the previous result is unread. A new transaction is taken only in S_IDLE, when done.
// Reset (synchronous, rst_n low): registers but the payload ones take their defaults, field state clears at once.
`timescale 1ns / 1ps
module streaming_integer_text_parser_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  sitp_in_if.sink                       in_ch,
  sitp_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [sitp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sitp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sitp_pkg::*;

  sitp_cmd_t cmd;
  sitp_sts_t sts;

  sitp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sitp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_char   (in_ch.char_in),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .value_out (out_ch.value_out),
    .status    (out_ch.status)
  );

endmodule
